// File: hw/rtl/remote_terminal_mode_code_event_log_macros.svh
// Assertion macros shared by the remote terminal event log RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef REMOTE_TERMINAL_MODE_CODE_EVENT_LOG_MACROS_SVH
`define REMOTE_TERMINAL_MODE_CODE_EVENT_LOG_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define RTMCEL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define RTMCEL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/rtmcel_pkg.sv
// Types, constants and the mode code field table of the remote terminal event log.
// No dependencies.
package rtmcel_pkg;

  // Operation codes carried in the input tuser.
  typedef enum logic [1:0] {
    OP_MODE_CMD  = 2'd0,
    OP_TRANSFER  = 2'd1,
    OP_IRQ_CLEAR = 2'd2
  } op_e;

  // Configuration register indexes.
  localparam logic [7:0] CFG_MODE_CODE_CTRL = 8'd0;
  localparam logic [7:0] CFG_LOG_SIZE_MASK  = 8'd1;
  localparam logic [7:0] CFG_LOG_START      = 8'd2;
  localparam logic [7:0] CFG_EVENT_IRQ_EN   = 8'd3;

  localparam logic [31:0] MODE_CODE_CTRL_RESET = 32'h0000_0555;

  // Subaddress control bit positions.
  localparam int unsigned SA_BCRXE_BIT = 16;
  localparam int unsigned SA_RXEN_BIT  = 15;
  localparam int unsigned SA_RXIRQ_BIT = 13;
  localparam int unsigned SA_TXEN_BIT  = 7;
  localparam int unsigned SA_TXIRQ_BIT = 5;

  // Log entry kinds.
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_RX   = 2'd1;
  localparam logic [1:0] KIND_MODE = 2'd2;

  // Mode codes with special handling.
  localparam logic [4:0] MC_DYN_BUS_CTRL = 5'd0;
  localparam logic [4:0] MC_TX_VECTOR    = 5'd16;
  localparam logic [4:0] MC_SYNC_DATA    = 5'd17;
  localparam logic [4:0] MC_TX_BIT_WORD  = 5'd19;

  localparam logic [31:0] LOG_STEP = 32'd4;

  // Input item, last field in the lowest bits.
  typedef struct packed {
    logic [1:0]  pad;
    logic        clear_event_flag;
    logic [15:0] time_tag;
    logic        descriptor_present;
    logic        descriptor_irq_request;
    logic [16:0] subaddress_control;
    logic [5:0]  word_count;
    logic [15:0] data_word;
    logic        receive;
    logic        broadcast;
    logic [4:0]  subaddress;
    logic [4:0]  mode_code;
  } in_item_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic [4:0]  pad;
    logic [31:0] irq_mark_address;
    logic [31:0] sync_value;
    logic        interrupt_line;
    logic [31:0] log_entry;
    logic [31:0] log_address;
    logic        log_write;
    logic        accepted;
  } out_item_t;

  // Position of the two-bit field of a mode code in the control register.
  typedef struct packed {
    logic       hit;
    logic [4:0] shift;
  } field_sel_t;

  function automatic field_sel_t field_select(input logic [4:0] code);
    field_sel_t sel;
    sel.hit   = 1'b1;
    sel.shift = 5'd0;
    unique case (code)
      5'd0:        sel.shift = 5'd16;
      5'd1:        sel.shift = 5'd0;
      5'd3:        sel.shift = 5'd18;
      5'd4, 5'd5:  sel.shift = 5'd8;
      5'd6, 5'd7:  sel.shift = 5'd22;
      5'd8:        sel.shift = 5'd26;
      5'd16:       sel.shift = 5'd12;
      5'd17:       sel.shift = 5'd4;
      5'd19:       sel.shift = 5'd14;
      default:     sel.hit   = 1'b0;
    endcase
    return sel;
  endfunction

endpackage

// File: hw/rtl/remote_terminal_mode_code_event_log.sv
// Remote terminal mode code handler and event log, top level.
// Depends on rtmcel_pkg and remote_terminal_mode_code_event_log_macros.svh.
//
// Channel   Direction  Handshake                      Contents
// s_axis    in         s_axis_tvalid_i/tready_o       command, transfer or clear write
// m_axis    out        m_axis_tvalid_o/tready_i       one result per input transfer
// cfg       in         cfg_valid_i/cfg_ready_o        register index and write data
//
// Every input transfer yields exactly one result, held first in the input register and
// then in the result register.
// A new input transfer is taken every cycle while results drain; the sustained rate is
// one item per cycle, with the log pointer and flags updated as each item advances.
// Reset loads the register reset values and empties both registers.
// A stalled output holds its result; the input register then fills and tready drops.
module remote_terminal_mode_code_event_log
  import rtmcel_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata from bit 0: mode_code[5], subaddress[5], broadcast, receive, data_word[16],
  // word_count[6], subaddress_control[17], descriptor_irq_request, descriptor_present,
  // time_tag[16], clear_event_flag, two zero bits
  input  logic [71:0]  s_axis_tdata_i,
  // tuser from bit 0: operation[2]
  input  logic [1:0]   s_axis_tuser_i,
  // Result stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata from bit 0: accepted, log_write, log_address[32], log_entry[32],
  // interrupt_line, sync_value[32], irq_mark_address[32], five zero bits
  output logic [135:0] m_axis_tdata_o,
  // Configuration writes
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  // Configuration registers.
  logic [31:0] mode_ctrl_q;
  logic [31:0] size_mask_q;
  logic        irq_enable_q;

  // Block state.
  logic [31:0] log_pointer_q, log_pointer_d;
  logic [31:0] irq_mark_q, irq_mark_d;
  logic [31:0] sync_q, sync_d;
  logic        pending_q, pending_d;

  // Input and result registers.
  logic        in_valid_q;
  in_item_t    in_item_q;
  op_e         in_op_q;
  logic        out_valid_q;
  out_item_t   out_item_q, out_item_d;

  logic        advance;
  logic        cfg_write;

  // Decode signals.
  field_sel_t  sel;
  logic [4:0]  field_shift;
  logic [31:0] field_word;
  logic [1:0]  field;
  logic        bcast_banned;
  logic        mode_legal;
  logic        xfer_ok;
  logic        xfer_irq;
  logic        accept;
  logic        append;
  logic        entry_irq;
  logic [1:0]  entry_kind;
  logic [4:0]  entry_code;
  logic [5:0]  entry_count;
  logic [31:0] entry_word;
  logic [31:0] pointer_inc;
  logic [31:0] pointer_next;

  assign cfg_ready_o     = 1'b1;
  assign cfg_write       = cfg_valid_i & cfg_ready_o;
  assign advance         = in_valid_q & (~out_valid_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_valid_q | advance;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_item_q;

  // Mode code field lookup; a broadcast command uses the field two places up.
  always_comb begin
    sel          = field_select(in_item_q.mode_code);
    field_shift  = sel.shift + {3'd0, in_item_q.broadcast, 1'b0};
    field_word   = mode_ctrl_q >> field_shift;
    field        = field_word[1:0];
    bcast_banned = in_item_q.broadcast &
                   ((in_item_q.mode_code == MC_DYN_BUS_CTRL) ||
                    (in_item_q.mode_code == MC_TX_VECTOR) ||
                    (in_item_q.mode_code == MC_TX_BIT_WORD));
    mode_legal   = sel.hit & ~bcast_banned & (field != 2'd0);
  end

  // Transfer gating by the enable bits and the descriptor.
  always_comb begin
    xfer_ok = (in_item_q.receive ? in_item_q.subaddress_control[SA_RXEN_BIT]
                                 : in_item_q.subaddress_control[SA_TXEN_BIT]) &
              ~(in_item_q.broadcast & ~in_item_q.receive) &
              ~(in_item_q.broadcast & ~in_item_q.subaddress_control[SA_BCRXE_BIT]) &
              in_item_q.descriptor_present;
    xfer_irq = in_item_q.descriptor_irq_request |
               (in_item_q.receive & in_item_q.subaddress_control[SA_RXIRQ_BIT]) |
               (~in_item_q.receive & in_item_q.subaddress_control[SA_TXIRQ_BIT]);
  end

  // Operation select: acceptance, log entry contents, the sync value and the clear write.
  always_comb begin
    accept      = 1'b0;
    append      = 1'b0;
    entry_irq   = 1'b0;
    entry_kind  = KIND_MODE;
    entry_code  = in_item_q.mode_code;
    entry_count = 6'd0;
    sync_d      = sync_q;
    pending_d   = pending_q;
    case (in_op_q)
      OP_MODE_CMD: begin
        accept    = mode_legal;
        append    = mode_legal & field[1];
        entry_irq = field == 2'd3;
        if (mode_legal && in_item_q.mode_code == MC_SYNC_DATA) begin
          sync_d = {in_item_q.time_tag, in_item_q.data_word};
        end
      end
      OP_TRANSFER: begin
        accept      = xfer_ok;
        append      = xfer_ok;
        entry_irq   = xfer_irq;
        entry_kind  = in_item_q.receive ? KIND_RX : KIND_TX;
        entry_code  = in_item_q.subaddress;
        entry_count = in_item_q.word_count;
      end
      OP_IRQ_CLEAR: begin
        if (in_item_q.clear_event_flag) begin
          pending_d = 1'b0;
        end
      end
      default: ;
    endcase
    if (append && entry_irq) begin
      pending_d = 1'b1;
    end
  end

  // Ring pointer: bits set in the mask keep the base, the rest advance and wrap.
  always_comb begin
    entry_word   = {entry_irq, entry_kind, entry_code, 15'd0, entry_count, 3'd0};
    pointer_inc  = log_pointer_q + LOG_STEP;
    pointer_next = (log_pointer_q & size_mask_q) | (pointer_inc & ~size_mask_q);
    irq_mark_d   = irq_mark_q;
    if (append && entry_irq && !pending_q) begin
      irq_mark_d = log_pointer_q;
    end
  end

  // Next pointer; a write of the start address reloads it.
  always_comb begin
    log_pointer_d = log_pointer_q;
    if (advance && append) begin
      log_pointer_d = pointer_next;
    end
    if (cfg_write && cfg_index_i == CFG_LOG_START) begin
      log_pointer_d = cfg_data_i;
    end
  end

  // Result assembly from the state after this item.
  always_comb begin
    out_item_d                  = '0;
    out_item_d.accepted         = accept;
    out_item_d.log_write        = append;
    out_item_d.log_address      = append ? log_pointer_q : 32'd0;
    out_item_d.log_entry        = append ? entry_word : 32'd0;
    out_item_d.interrupt_line   = pending_d & irq_enable_q;
    out_item_d.sync_value       = sync_d;
    out_item_d.irq_mark_address = irq_mark_d;
  end

  // Configuration registers and block state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_ctrl_q   <= MODE_CODE_CTRL_RESET;
      size_mask_q   <= '0;
      irq_enable_q  <= 1'b0;
      log_pointer_q <= '0;
      irq_mark_q    <= '0;
      sync_q        <= '0;
      pending_q     <= 1'b0;
    end else begin
      log_pointer_q <= log_pointer_d;
      if (cfg_write) begin
        unique case (cfg_index_i)
          CFG_MODE_CODE_CTRL: mode_ctrl_q  <= cfg_data_i;
          CFG_LOG_SIZE_MASK:  size_mask_q  <= cfg_data_i;
          // The start address only reloads the log pointer.
          CFG_LOG_START:      ;
          CFG_EVENT_IRQ_EN:   irq_enable_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (advance) begin
        irq_mark_q <= irq_mark_d;
        sync_q     <= sync_d;
        pending_q  <= pending_d;
      end
    end
  end

  // Handshake state of the input and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_item_q <= in_item_t'(s_axis_tdata_i);
      in_op_q   <= op_e'(s_axis_tuser_i);
    end
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

`include "remote_terminal_mode_code_event_log_macros.svh"

  `RTMCEL_ASSERT_SAME(a_log_implies_accept,
    out_valid_q && out_item_q.log_write, out_item_q.accepted,
    "log entry written for a rejected item")
  `RTMCEL_ASSERT_SAME(a_no_log_zero,
    out_valid_q && !out_item_q.log_write,
    out_item_q.log_address == 32'd0 && out_item_q.log_entry == 32'd0,
    "address or entry set without a log write")
  `RTMCEL_ASSERT_NEXT(a_mark_moves,
    advance && append && entry_irq && !pending_q,
    irq_mark_q == $past(log_pointer_q) && pending_q,
    "interrupt mark not taken from the log pointer")

endmodule
